// ===== src/luit_pkg.sv =====
// Shared types and constants of the lazy unit-initialization tracker.
// Depends on nothing; the top level imports it.
`default_nettype none

package luit_pkg;

  // Sizing of the tracked memory and the fix-up bursts.
  localparam int MEMORY_UNITS      = 4096;
  localparam int STACK_UNITS       = 512;
  localparam int GEN_WIDTH         = 16;
  localparam int HEAP_BURST_UNITS  = 8;
  localparam int STACK_BURST_UNITS = 2;

  localparam int UNIT_W  = 12;
  localparam int ADDR_W  = $clog2(MEMORY_UNITS);
  localparam int BURST_MAX = (HEAP_BURST_UNITS > STACK_BURST_UNITS) ?
                             HEAP_BURST_UNITS : STACK_BURST_UNITS;
  localparam int CNT_W   = $clog2(BURST_MAX + 1);
  localparam int HEAP_W  = 15;

  // Operation codes
  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_EPOCH  = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_ZERO     = 3'd1;
  localparam logic [2:0] ACT_COPY     = 3'd2;
  localparam logic [2:0] ACT_OVERFLOW = 3'd3;
  localparam logic [2:0] ACT_CLEARED  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_TRACK_DIS  = 1'b0;
  localparam logic CFG_HEAP_START = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [UNIT_W-1:0] unit_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [UNIT_W-1:0] target_unit;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    KIND_STACK,
    KIND_HEAP,
    KIND_COPY
  } kind_t;

endpackage

`default_nettype wire

// ===== src/luit_gen_ram.sv =====
// Simple dual-port synchronous RAM for the per-unit generation table.
// One write and one registered read per cycle; generic, no package needed.
`default_nettype none

module luit_gen_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lazy_unit_init_tracker.sv =====
// Top level of the lazy unit-initialization tracker: control FSM and result register.
// Depends on luit_pkg and luit_gen_ram.
//
// Usage: the block keeps, per 8-byte unit, the generation in which the unit was
// last made valid, in a single-read-port synchronous RAM. A transaction is taken
// when start is high and busy is low. Mark, new-generation ops that do not wrap,
// unknown ops and accesses with tracking disabled leave the block idle, so they
// may follow each other every cycle. An access with tracking enabled reads one
// table entry per cycle: it holds busy while it examines units (one per zeroed
// unit plus the one that stops the burst on a valid entry), and for a flush step
// when a burst of more than one unit ends without meeting a valid unit (on its
// length, at unit one or at the end of memory). Results leave through a register,
// one per cycle at most, each shown for exactly one cycle with out_valid high;
// the receiver cannot stall them, so they must be taken as they come. The last
// result of a transaction has last set. After reset, and after a new-generation
// op that wraps the generation counter (result action "table cleared"), the
// block clears all MEMORY_UNITS (4096) table entries with busy high; configuration
// writes are taken at any time but are meant to be issued only while the block
// is idle.
`default_nettype none

module lazy_unit_init_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // command channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire luit_pkg::in_item_t               in_item,
  // result channel
  output logic                                  out_valid,
  output luit_pkg::out_item_t                   out_item,
  // configuration channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_index,
  input  wire logic [luit_pkg::HEAP_W-1:0]      cfg_data
);

  import luit_pkg::*;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic [GEN_WIDTH-1:0]   gen_r, gen_nxt;          // current generation
  logic                   track_dis_r, track_dis_nxt;
  logic [HEAP_W-1:0]      heap_r, heap_nxt;        // heap start byte
  kind_t                  kind_r, kind_nxt;        // region of the accessed unit
  logic [ADDR_W-1:0]      cur_r, cur_nxt;          // unit whose entry is being read
  logic [ADDR_W-1:0]      pend_r, pend_nxt;        // zeroed unit awaiting its result
  logic [CNT_W-1:0]       count_r, count_nxt;      // units zeroed so far
  logic [ADDR_W-1:0]      clr_r, clr_nxt;          // clearing pass pointer
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  // RAM interface
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [GEN_WIDTH-1:0]   wr_data;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [GEN_WIDTH-1:0]   rd_data;

  luit_gen_ram #(
    .DEPTH (MEMORY_UNITS),
    .WIDTH (GEN_WIDTH),
    .AW    (ADDR_W)
  ) u_gen_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Decode of the incoming transaction and of the entry just read
  // ---------------------------------------------------------------------------
  logic                 accept;
  logic                 in_range;
  logic                 is_stack;
  logic                 is_heap;
  logic                 gen_wrap;
  logic                 hit;
  logic                 more;
  logic [CNT_W-1:0]     count_inc;
  logic [ADDR_W-1:0]    next_unit;
  logic [ADDR_W-1:0]    in_addr;

  assign accept    = start && (state_r == ST_IDLE);
  assign in_range  = int'(in_item.unit_index) < MEMORY_UNITS;
  assign in_addr   = ADDR_W'(in_item.unit_index);
  assign is_stack  = int'(in_item.unit_index) < STACK_UNITS;
  assign is_heap   = (heap_r != '0) && ({in_item.unit_index, 3'b000} >= heap_r);
  assign gen_wrap  = (gen_r == '1);
  assign hit       = (rd_data == gen_r);
  assign count_inc = count_r + CNT_W'(1);

  // Decide whether the burst may step to one more unit after this one.
  always_comb begin
    if (kind_r == KIND_STACK) begin
      more      = (cur_r > ADDR_W'(1)) && (count_inc < CNT_W'(STACK_BURST_UNITS));
      next_unit = cur_r - ADDR_W'(1);
    end else begin
      more      = (cur_r != ADDR_W'(MEMORY_UNITS - 1)) &&
                  (count_inc < CNT_W'(HEAP_BURST_UNITS));
      next_unit = cur_r + ADDR_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(MEMORY_UNITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_item.op == OP_EPOCH) begin
            state_nxt = gen_wrap ? ST_CLEAR : ST_IDLE;
          end else if (in_item.op == OP_ACCESS && in_range && !track_dis_r) begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (!hit && kind_r != KIND_COPY && cur_r != '0 && more) begin
          state_nxt = ST_WALK;
        end else if (!hit && kind_r == KIND_HEAP && more) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (hit) begin
          state_nxt = ST_IDLE;
        end else if (!more) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath, RAM accesses and results
  // ---------------------------------------------------------------------------
  always_comb begin
    gen_nxt       = gen_r;
    kind_nxt      = kind_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    count_nxt     = count_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = gen_r;
    rd_en         = 1'b0;
    rd_addr       = next_unit;

    unique case (state_r)
      ST_CLEAR: begin
        // sweep the table back to generation zero
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        clr_nxt = '0;
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{action: ACT_NONE, target_unit: in_item.unit_index,
                            last: 1'b1};
          if (in_item.op == OP_EPOCH) begin
            out_item_nxt.target_unit = '0;
            if (gen_wrap) begin
              gen_nxt             = GEN_WIDTH'(1);
              out_item_nxt.action = ACT_CLEARED;
            end else begin
              gen_nxt = gen_r + GEN_WIDTH'(1);
            end
          end else if (in_item.op == OP_MARK && in_range) begin
            wr_en   = 1'b1;
            wr_addr = in_addr;
          end else if (in_item.op == OP_ACCESS && in_range && !track_dis_r) begin
            // look the unit up; the result goes out once its entry is back
            out_valid_nxt = 1'b0;
            rd_en         = 1'b1;
            rd_addr       = in_addr;
            cur_nxt       = in_addr;
            count_nxt     = '0;
            if (is_stack) begin
              kind_nxt = KIND_STACK;
            end else if (is_heap) begin
              kind_nxt = KIND_HEAP;
            end else begin
              kind_nxt = KIND_COPY;
            end
          end
        end
      end
      ST_LOOKUP: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{action: ACT_NONE, target_unit: UNIT_W'(cur_r), last: 1'b1};
        if (!hit) begin
          if (kind_r == KIND_COPY) begin
            wr_en               = 1'b1;
            out_item_nxt.action = ACT_COPY;
          end else if (kind_r == KIND_STACK && cur_r == '0) begin
            // nothing below unit zero: report overflow, mark nothing
            out_item_nxt.action      = ACT_OVERFLOW;
            out_item_nxt.target_unit = '0;
          end else begin
            wr_en               = 1'b1;
            count_nxt           = count_inc;
            out_item_nxt.action = ACT_ZERO;
            if (more) begin
              // hold this result until the next entry tells whether it is last
              out_valid_nxt = 1'b0;
              pend_nxt      = cur_r;
              rd_en         = 1'b1;
              cur_nxt       = next_unit;
            end
          end
        end
      end
      ST_WALK: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{action: ACT_ZERO, target_unit: UNIT_W'(pend_r), last: hit};
        if (!hit) begin
          wr_en     = 1'b1;
          count_nxt = count_inc;
          pend_nxt  = cur_r;
          if (more) begin
            rd_en   = 1'b1;
            cur_nxt = next_unit;
          end
        end
      end
      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{action: ACT_ZERO, target_unit: UNIT_W'(pend_r), last: 1'b1};
      end
      default: ;
    endcase
  end

  // Configuration writes
  always_comb begin
    track_dis_nxt = track_dis_r;
    heap_nxt      = heap_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRACK_DIS:  track_dis_nxt = cfg_data[0];
        CFG_HEAP_START: heap_nxt      = cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      gen_r       <= GEN_WIDTH'(1);
      track_dis_r <= 1'b1;
      heap_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      track_dis_r <= track_dis_nxt;
      heap_r      <= heap_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    cur_r      <= cur_nxt;
    pend_r     <= pend_nxt;
    count_r    <= count_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != '0)
    else $error("current generation is zero");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("table read and write hit the same entry in one cycle");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.last && out_item_r.action != ACT_CLEARED |-> !busy)
    else $error("final result shown while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.last |-> busy && out_item_r.action == ACT_ZERO)
    else $error("non-final result outside a zeroing burst");

  a_clear_enters: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && state_nxt == ST_CLEAR |=> out_valid_r &&
      out_item_r.action == ACT_CLEARED && gen_r == GEN_WIDTH'(1))
    else $error("table clear started without a wrap result");

endmodule

`default_nettype wire
